>>> hw/rtl/crp_pkg.sv
package crp_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_BYTE       = 2'd0;
    localparam logic [1:0] KIND_FREQ_QUERY = 2'd1;
    localparam logic [1:0] KIND_MODE_QUERY = 2'd2;

    // Report kinds on the output tuser
    localparam logic REPORT_FREQ = 1'b0;
    localparam logic REPORT_MODE = 1'b1;

    // Characters of the reply grammar
    localparam logic [7:0] CH_END   = 8'h3b;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_M     = 8'h4d;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Frame geometry
    localparam int MAX_FRAME_BYTES = 512;
    localparam int FREQ_DIGITS     = 11;
    localparam int CNT_W           = 10;
    localparam int FREQ_W          = 37;
    localparam int MODE_W          = 4;
    localparam logic [CNT_W-1:0] FREQ_FRAME_LEN = CNT_W'(2 + FREQ_DIGITS);
    localparam logic [CNT_W-1:0] MODE_FRAME_LEN = CNT_W'(3);
    localparam logic [CNT_W-1:0] MAX_FRAME_CNT  = CNT_W'(MAX_FRAME_BYTES);

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_LSB   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_USB   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_CWL   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_FM    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_AM    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DIGU  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CWU   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DIGL  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_WRONG = 4'd8;

    // Job queue between parser and report stage
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // Register map
    localparam int          APB_ADDR_W   = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_ALT_DIALECT = 3'd0;

    // Pending request held by the parser
    typedef enum logic [1:0] {
        REQ_NONE = 2'd0,
        REQ_FREQ = 2'd1,
        REQ_MODE = 2'd2
    } t_req;

    // One matched answer, handed from parser to report stage
    typedef struct packed {
        logic              is_mode;
        logic              two_reports;
        logic [FREQ_W-1:0] freq;
        logic [MODE_W-1:0] mode;
    } t_job;

    function automatic logic [MODE_W-1:0] mode_of(input logic [7:0] c);
        logic [MODE_W-1:0] m;
        case (c)
            8'h31:   m = MODE_LSB;
            8'h32:   m = MODE_USB;
            8'h33:   m = MODE_CWL;
            8'h34:   m = MODE_FM;
            8'h35:   m = MODE_AM;
            8'h36:   m = MODE_DIGU;
            8'h37:   m = MODE_CWU;
            8'h39:   m = MODE_DIGL;
            default: m = MODE_WRONG;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/crp_front.sv
module crp_front
    import crp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_alt_dialect,
    input  logic       i_valid,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_byte,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);

    t_req              r_req,   n_req;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [7:0]        r_c0,    n_c0;
    logic [7:0]        r_c1,    n_c1;
    logic [7:0]        r_c2,    n_c2;
    logic [FREQ_W-1:0] r_acc,   n_acc;
    logic              r_dig_ok, n_dig_ok;

    logic              take;
    logic              is_digit;
    logic              in_digits;
    logic [7:0]        id_char;
    logic              freq_hit;
    logic              mode_hit;
    logic [FREQ_W-1:0] acc_step;

    assign o_ready = !i_full;
    assign take    = i_valid && o_ready;

    // running decimal accumulation: acc*10 + digit
    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign in_digits = (r_cnt >= CNT_W'(2)) && (r_cnt < FREQ_FRAME_LEN);
    assign acc_step  = {r_acc[FREQ_W-4:0], 3'b000} + {r_acc[FREQ_W-2:0], 1'b0}
                     + {{(FREQ_W-4){1'b0}}, i_byte[3:0]};

    // frame matching at the terminator
    assign id_char  = i_alt_dialect ? CH_COMMA : CH_A;
    assign freq_hit = (r_req == REQ_FREQ) && (r_c0 == CH_F) && (r_c1 == id_char)
                   && (r_cnt == FREQ_FRAME_LEN);
    assign mode_hit = (r_req == REQ_MODE) && (r_c0 == CH_M) && (r_c1 == CH_D)
                   && (r_cnt == MODE_FRAME_LEN);

    always_comb begin
        n_req    = r_req;
        n_cnt    = r_cnt;
        n_c0     = r_c0;
        n_c1     = r_c1;
        n_c2     = r_c2;
        n_acc    = r_acc;
        n_dig_ok = r_dig_ok;
        o_push   = 1'b0;

        o_job.is_mode     = mode_hit;
        o_job.two_reports = i_alt_dialect && !mode_hit;
        o_job.freq        = (r_dig_ok && !mode_hit) ? r_acc : '0;
        o_job.mode        = mode_hit ? mode_of(r_c2) : MODE_LSB;

        if (take) begin
            case (i_kind)
                KIND_FREQ_QUERY: begin
                    n_req = REQ_FREQ;
                end
                KIND_MODE_QUERY: begin
                    n_req = i_alt_dialect ? REQ_FREQ : REQ_MODE;
                end
                KIND_BYTE: begin
                    if (i_byte != CH_END) begin
                        if (r_cnt == CNT_W'(0)) n_c0 = i_byte;
                        if (r_cnt == CNT_W'(1)) n_c1 = i_byte;
                        if (r_cnt == CNT_W'(2)) n_c2 = i_byte;
                        if (in_digits) begin
                            if (is_digit) n_acc = acc_step;
                            else          n_dig_ok = 1'b0;
                        end
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    // terminator, or overlong frame: start over
                    if ((i_byte == CH_END) || (r_cnt >= MAX_FRAME_CNT)) begin
                        n_cnt    = '0;
                        n_c0     = '0;
                        n_c1     = '0;
                        n_c2     = '0;
                        n_acc    = '0;
                        n_dig_ok = 1'b1;
                    end
                    if ((i_byte == CH_END) && (r_cnt >= MODE_FRAME_LEN)
                        && (freq_hit || mode_hit)) begin
                        o_push = 1'b1;
                        n_req  = REQ_NONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req    <= REQ_NONE;
            r_cnt    <= '0;
            r_c0     <= '0;
            r_c1     <= '0;
            r_c2     <= '0;
            r_acc    <= '0;
            r_dig_ok <= 1'b1;
        end else begin
            r_req    <= n_req;
            r_cnt    <= n_cnt;
            r_c0     <= n_c0;
            r_c1     <= n_c1;
            r_c2     <= n_c2;
            r_acc    <= n_acc;
            r_dig_ok <= n_dig_ok;
        end
    end

endmodule

>>> hw/rtl/crp_fifo.sv
module crp_fifo
    import crp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == JOB_CNT_W'(JOB_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_job;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + JOB_PTR_W'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + JOB_PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + JOB_CNT_W'(1);
                2'b01:   r_count <= r_count - JOB_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/crp_back.sv
module crp_back
    import crp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_kind,
    output logic [FREQ_W-1:0] o_freq,
    output logic [MODE_W-1:0] o_mode,
    output logic              o_last
);

    logic              r_valid;
    logic              r_second;
    logic              r_kind;
    logic [FREQ_W-1:0] r_freq;
    logic [MODE_W-1:0] r_mode;
    logic              r_last;
    logic              load;

    // output register free, or being drained this cycle
    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_second && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            if (r_second) begin
                r_valid  <= 1'b1;
                r_second <= 1'b0;
            end else begin
                r_valid  <= i_job_valid;
                r_second <= i_job_valid && !i_job.is_mode && i_job.two_reports;
            end
        end
    end

    // payload: follow-up USB report, else the head job's report
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_second) begin
                r_kind <= REPORT_MODE;
                r_freq <= '0;
                r_mode <= MODE_USB;
                r_last <= 1'b1;
            end else begin
                r_kind <= i_job.is_mode ? REPORT_MODE : REPORT_FREQ;
                r_freq <= i_job.freq;
                r_mode <= i_job.mode;
                r_last <= i_job.is_mode || !i_job.two_reports;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_freq  = r_freq;
    assign o_mode  = r_mode;
    assign o_last  = r_last;

endmodule

>>> hw/rtl/cat_response_parser_top.sv
// A reply's first report is offered on m_axis once its ';' has pushed a job into the job
// queue and the back stage has loaded that job into its output register.
// Throughput: one input item per cycle; s_axis stalls only while the job queue is full.
// A comma-dialect frequency answer gives two reports: the frequency, then a USB mode report.
// A four-entry job queue decouples the parser from the output register.
// Reset (i_rst_n low, synchronous) clears the register, pending request, frame and queue.
module cat_response_parser_top
    import crp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]            s_axis_tuser,   // [1:0] kind
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,   // [36:0] frequency_hz, [40:37] mode_code
    output logic                  m_axis_tuser,   // [0] report_kind
    output logic                  m_axis_tlast    // last_result
);

    logic              r_alt_dialect;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    t_job              q_in_job;
    t_job              q_out_job;
    logic [FREQ_W-1:0] out_freq;
    logic [MODE_W-1:0] out_mode;

    // register access
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ALT_DIALECT) ? {31'b0, r_alt_dialect} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_dialect <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_ALT_DIALECT)) begin
            r_alt_dialect <= pwdata[0];
        end
    end

    crp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_alt_dialect (r_alt_dialect),
        .i_valid       (s_axis_tvalid),
        .i_kind        (s_axis_tuser),
        .i_byte        (s_axis_tdata),
        .i_full        (q_full),
        .o_ready       (s_axis_tready),
        .o_push        (q_push),
        .o_job         (q_in_job)
    );

    crp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    crp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_out_job),
        .o_pop       (q_pop),
        .i_ready     (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_kind      (m_axis_tuser),
        .o_freq      (out_freq),
        .o_mode      (out_mode),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, out_mode, out_freq};

endmodule

>>> hw/rtl/crp_checker.sv
module crp_checker
    import crp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // nothing is offered in the cycle after a reset cycle
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("report offered right after reset");

    // a stalled report stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("report dropped while stalled");

    // mode reports carry no frequency, a valid code, and end the request
    a_mode_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == REPORT_MODE)) |->
        (m_axis_tdata[36:0] == '0) && (m_axis_tdata[40:37] <= MODE_WRONG) && m_axis_tlast)
        else $error("malformed mode report");

    // frequency reports carry mode code zero
    a_freq_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == REPORT_FREQ)) |->
        (m_axis_tdata[40:37] == MODE_LSB))
        else $error("frequency report with a mode code");

    // a non-final frequency report is followed at once by the USB mode report
    a_follow_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && (m_axis_tuser == REPORT_FREQ) && !m_axis_tlast)
        |=> (m_axis_tvalid && (m_axis_tuser == REPORT_MODE)
             && (m_axis_tdata[40:37] == MODE_USB)))
        else $error("missing follow-up mode report");

endmodule

bind cat_response_parser_top crp_checker u_crp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
